### sv/fftr4_pkg.sv
// fftr4_pkg: shared types, constants and the quarter-wave sine table of the
// radix-4 FFT engine. No dependencies; imported by every module of the block.
package fftr4_pkg;

  localparam int POINTS  = 1024;
  localparam int LOG_PTS = 10;
  localparam int STAGES  = LOG_PTS / 2;
  localparam int QUARTER = POINTS / 4;
  localparam int BF_W    = LOG_PTS - 2;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  typedef logic [LOG_PTS-1:0] idx_t;

  typedef struct packed {
    logic signed [15:0] im;
    logic signed [15:0] re;
  } cplx_t;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  typedef enum logic {
    CORE_IDLE,
    CORE_RUN
  } core_state_e;

  // request from the stream front end to the transform core
  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    logic  start;
    idx_t  addr;
    cplx_t wdata;
  } core_req_t;

  typedef struct packed {
    logic  done;
    cplx_t rdata;
  } core_rsp_t;

  // one operation of the shared multiply-accumulate unit
  typedef struct packed {
    logic               en;
    logic               clr;
    logic               sub;
    logic signed [16:0] x;
    logic signed [15:0] w;
  } mac_op_t;

  typedef logic [16:0] sine_tbl_t [QUARTER+1];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // floor(32768 * sin(2*pi*m/POINTS)) for the first quadrant, exact integer series
  function automatic sine_tbl_t build_sine();
    sine_tbl_t   t;
    logic [63:0] q, r, x, x2, term, sum, v;
    int          k;
    q = TWO_PI_Q60 / POINTS;
    r = TWO_PI_Q60 % POINTS;
    for (int m = 0; m <= QUARTER; m++) begin
      x    = 64'd4 * (q * 64'(m) + (r * 64'(m)) / POINTS);
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (k = 1; k < 24 && term != 64'd0; k++) begin
        term = mul_q62(term, x2) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      v    = sum >> 47;
      t[m] = (v > 64'd32768) ? 17'd32768 : v[16:0];
    end
    return t;
  endfunction

  localparam sine_tbl_t SINE_MAG = build_sine();

endpackage

### sv/fftr4_twiddle.sv
// fftr4_twiddle: Q15 cosine/sine lookup folded from the quarter-wave table,
// registered output. Depends on fftr4_pkg.
module fftr4_twiddle
  import fftr4_pkg::*;
(
  input  logic               clk_i,
  input  idx_t               idx_i,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  logic signed [15:0] cos_d, sin_d, cos_q, sin_q;

  function automatic logic [15:0] sine_at(input idx_t i);
    logic [LOG_PTS-3:0] r;
    logic [16:0]        mag;
    logic [16:0]        neg;
    r = i[LOG_PTS-3:0];
    if (i[LOG_PTS-2]) mag = SINE_MAG[9'(QUARTER) - {1'b0, r}];
    else mag = SINE_MAG[{1'b0, r}];
    neg = 17'd0 - mag;
    if (i[LOG_PTS-1]) return neg[15:0];
    return (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
  endfunction

  always_comb begin
    sin_d = sine_at(idx_i);
    cos_d = sine_at(idx_i + idx_t'(QUARTER));
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
    sin_q <= sin_d;
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

### sv/fftr4_mac.sv
// fftr4_mac: shared 17x16 multiplier with a registered product and a 32-bit
// accumulator that keeps the wrapped low bits. Depends on fftr4_pkg.
module fftr4_mac
  import fftr4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mac_op_t     op_i,
  output logic [31:0] acc_o
);

  logic signed [32:0] prod_full;
  logic [31:0]        prod_q, acc_q, acc_d, base;
  logic               vld_q, clr_q, sub_q;

  assign prod_full = $signed(op_i.x) * $signed(op_i.w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= op_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      prod_q <= prod_full[31:0];
      clr_q  <= op_i.clr;
      sub_q  <= op_i.sub;
    end
    if (vld_q) acc_q <= acc_d;
  end

  always_comb begin
    base  = clr_q ? 32'd0 : acc_q;
    acc_d = sub_q ? base - prod_q : base + prod_q;
  end

  assign acc_o = acc_q;

endmodule

### sv/fftr4_core.sv
// fftr4_core: sample and bin memories plus the butterfly sequencer that walks
// the radix-4 stages through one shared MAC. Depends on fftr4_pkg, fftr4_mac,
// fftr4_twiddle.
module fftr4_core
  import fftr4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_req_t req_i,
  output core_rsp_t rsp_o
);

  localparam logic [4:0] ST_TERMS = 5'd5;
  localparam logic [4:0] ST_MAC0  = 5'd6;
  localparam logic [4:0] ST_MACN  = 5'd17;
  localparam logic [4:0] ST_RES0  = 5'd9;
  localparam logic [4:0] ST_RESN  = 5'd19;
  localparam logic [4:0] ST_WR0   = 5'd20;
  localparam logic [4:0] ST_LAST  = 5'd23;

  core_state_e        state_q, state_d;
  logic [4:0]         st_q;
  logic [2:0]         stage_q;
  logic [BF_W-1:0]    bf_q;

  cplx_t              smem [POINTS];
  cplx_t              bmem [POINTS];
  cplx_t              s_rdata_q, b_rdata_q;

  cplx_t              x_q [4];
  cplx_t              y0_q;
  cplx_t              res_q [3];
  logic signed [16:0] ta_q, tb_q, tc_q, td_q, te_q, tf_q;

  logic               run, last_stage, last_bf, done;
  idx_t               leg_adr, g, w1, tw_idx;
  logic               s_we, s_re, b_we;
  idx_t               s_addr, b_waddr;
  cplx_t              wr_data;
  logic [4:0]         rel, rel2;
  mac_op_t            mac_op;
  logic [31:0]        acc;
  logic signed [15:0] tw_cos, tw_sin;
  logic signed [16:0] op_x, op_y;

  function automatic logic signed [17:0] ext(input logic [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

  function automatic idx_t digit_rev(input idx_t v);
    idx_t r;
    for (int j = 0; j < LOG_PTS / 2; j++) begin
      r[2*j +: 2] = v[LOG_PTS-2-2*j +: 2];
    end
    return r;
  endfunction

  // butterfly n of stage s: leg digit k sits just above the group bits
  always_comb begin
    logic [3:0] ll;
    idx_t       wide, up;
    ll      = {3'(STAGES - 1) - stage_q, 1'b0};
    wide    = {2'b00, bf_q};
    g       = wide & ((idx_t'(1) << ll) - idx_t'(1));
    up      = (wide >> ll) << (ll + 4'd2);
    leg_adr = up | (idx_t'(st_q[1:0]) << ll) | g;
    w1      = g << {stage_q, 1'b0};
  end

  assign run        = (state_q == CORE_RUN);
  assign last_stage = (stage_q == 3'(STAGES - 1));
  assign last_bf    = (bf_q == {BF_W{1'b1}});
  assign done       = run && st_q == ST_LAST && last_bf && last_stage;
  assign rel        = st_q - ST_MAC0;
  assign rel2       = st_q - ST_RES0;

  always_comb begin
    if (st_q <= 5'd8) tw_idx = w1;
    else if (st_q <= 5'd12) tw_idx = w1 << 1;
    else tw_idx = w1 + (w1 << 1);
  end

  fftr4_twiddle u_twiddle (
    .clk_i (clk_i),
    .idx_i (tw_idx),
    .cos_o (tw_cos),
    .sin_o (tw_sin)
  );

  // leg m: re = X*cos + Y*sin, im = Y*cos - X*sin
  always_comb begin
    case (rel[3:2])
      2'd0: begin op_x = ta_q; op_y = td_q; end
      2'd1: begin op_x = tb_q; op_y = te_q; end
      default: begin op_x = tc_q; op_y = tf_q; end
    endcase
    mac_op.en  = run && st_q >= ST_MAC0 && st_q <= ST_MACN;
    mac_op.clr = ~rel[0];
    mac_op.sub = (rel[1:0] == 2'd3);
    mac_op.x   = (rel[1:0] == 2'd0 || rel[1:0] == 2'd3) ? op_x : op_y;
    mac_op.w   = (rel[1:0] == 2'd1 || rel[1:0] == 2'd3) ? tw_sin : tw_cos;
  end

  fftr4_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mac_op),
    .acc_o  (acc)
  );

  always_comb begin
    wr_data = (st_q[1:0] == 2'd0) ? y0_q : res_q[2'(st_q[1:0] - 2'd1)];
    s_re    = run && st_q < 5'd4;
    s_we    = (run && st_q >= ST_WR0 && !last_stage) || req_i.wr_en;
    s_addr  = run ? leg_adr : req_i.addr;
    b_we    = run && st_q >= ST_WR0 && last_stage;
    b_waddr = digit_rev(leg_adr);
  end

  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_addr] <= run ? wr_data : req_i.wdata;
    if (s_re) s_rdata_q <= smem[s_addr];
    if (b_we) bmem[b_waddr] <= wr_data;
    if (req_i.rd_en) b_rdata_q <= bmem[req_i.addr];
  end

  // operand capture and the adder terms
  always_ff @(posedge clk_i) begin
    logic signed [17:0] r0, r1, r2, r3, i0, i1, i2, i3, s0r, s0i;
    logic signed [17:0] sa, sb, sc, sd, se, sf;
    r0 = ext(x_q[0].re); r1 = ext(x_q[1].re); r2 = ext(x_q[2].re); r3 = ext(x_q[3].re);
    i0 = ext(x_q[0].im); i1 = ext(x_q[1].im); i2 = ext(x_q[2].im); i3 = ext(x_q[3].im);
    s0r = r0 + r1 + r2 + r3;
    s0i = i0 + i1 + i2 + i3;
    sa  = r0 + i1 - r2 - i3;
    sb  = r0 - r1 + r2 - r3;
    sc  = r0 - i1 - r2 + i3;
    sd  = i0 - r1 - i2 + r3;
    se  = i0 - i1 + i2 - i3;
    sf  = i0 + r1 - i2 - r3;
    if (run && st_q >= 5'd1 && st_q <= 5'd4) x_q[2'(st_q - 5'd1)] <= s_rdata_q;
    if (run && st_q == ST_TERMS) begin
      y0_q.re <= s0r[17:2];
      y0_q.im <= s0i[17:2];
      ta_q <= sa[17:1]; tb_q <= sb[17:1]; tc_q <= sc[17:1];
      td_q <= sd[17:1]; te_q <= se[17:1]; tf_q <= sf[17:1];
    end
    if (run && st_q >= ST_RES0 && st_q <= ST_RESN) begin
      if (rel2[1:0] == 2'd0) res_q[rel2[3:2]].re <= acc[31:16];
      if (rel2[1:0] == 2'd2) res_q[rel2[3:2]].im <= acc[31:16];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CORE_IDLE: if (req_i.start) state_d = CORE_RUN;
      CORE_RUN:  if (done) state_d = CORE_IDLE;
      default:   state_d = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      st_q    <= 5'd0;
      stage_q <= 3'd0;
      bf_q    <= '0;
    end else begin
      state_q <= state_d;
      if (!run) begin
        st_q    <= 5'd0;
        stage_q <= 3'd0;
        bf_q    <= '0;
      end else if (st_q == ST_LAST) begin
        st_q <= 5'd0;
        bf_q <= bf_q + 1'b1;
        if (last_bf) stage_q <= stage_q + 3'd1;
      end else begin
        st_q <= st_q + 5'd1;
      end
    end
  end

  assign rsp_o.done  = done;
  assign rsp_o.rdata = b_rdata_q;

endmodule

### sv/fft_radix4_dif_fixed.sv
// fft_radix4_dif_fixed: stream front end of the 1024-point radix-4 DIF FFT.
// Depends on fftr4_pkg and fftr4_core.
//
//   channel  dir  tuser           tdata
//   s_axis   in   func            point_index, sample_real, sample_imag
//   m_axis   out  out_kind        out_index, out_real, out_imag
//
// Write results load as the item is accepted; read results wait for the
// registered bin memory read. A run item holds tready low while the core
// steps 5 stages x 256 butterflies through the single shared MAC and the
// single-port sample memory. Reset clears control only; memory contents
// persist undefined. One result register; input is taken while it drains.
module fft_radix4_dif_fixed
  import fftr4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // point_index[9:0], sample_real, sample_imag, pad
  input  logic [1:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_index[9:0], out_real, out_imag, pad
  output logic [1:0]  m_axis_tuser    // out_kind
);

  logic      accept, load, run_q, rd_pend_q, out_vld_q;
  func_e     func;
  idx_t      in_idx, idx_q, out_idx_q;
  kind_e     kind_q, kind_d;
  cplx_t     data_q, data_d;
  core_req_t req;
  core_rsp_t rsp;

  assign func          = func_e'(s_axis_tuser);
  assign in_idx        = s_axis_tdata[9:0];
  assign s_axis_tready = !run_q && !rd_pend_q && (!out_vld_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req.wr_en    = accept && func == FUNC_WRITE;
    req.rd_en    = accept && func == FUNC_READ;
    req.start    = accept && func == FUNC_RUN;
    req.addr     = in_idx;
    req.wdata.re = s_axis_tdata[25:10];
    req.wdata.im = s_axis_tdata[41:26];
  end

  fftr4_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_comb begin
    load   = req.wr_en || rd_pend_q || rsp.done;
    kind_d = KIND_ACK;
    data_d = '0;
    if (rd_pend_q) begin
      kind_d = KIND_DATA;
      data_d = rsp.rdata;
    end else if (rsp.done) begin
      kind_d = KIND_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      rd_pend_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_pend_q <= req.rd_en;
      if (req.start) run_q <= 1'b1;
      else if (rsp.done) run_q <= 1'b0;
      if (load) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) idx_q <= in_idx;
    if (load) begin
      kind_q    <= kind_d;
      data_q    <= data_d;
      out_idx_q <= req.wr_en ? in_idx : idx_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {6'd0, data_q.im, data_q.re, out_idx_q};

endmodule

### sim/tb_fft_radix4_dif_fixed.sv
// tb_fft_radix4_dif_fixed: self-checking stream testbench of the radix-4 FFT engine.
// Depends on fftr4_pkg and fft_radix4_dif_fixed. Mirrors sample/bin stores and
// the Q15 twiddle table, predicts every result item and compares them in order.
module tb_fft_radix4_dif_fixed;
  import fftr4_pkg::*;

  localparam int          NPTS    = 1024;
  localparam int          QTR     = NPTS / 4;
  localparam logic [63:0] PI2_Q60 = 64'h6487ED5110B4611A;
  localparam int          WD_MAX  = 100000;

  typedef struct {
    kind_e       kind;
    logic [9:0]  idx;
    logic [15:0] re;
    logic [15:0] im;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  result_t result_q[$];
  int      errors = 0;
  int      src_idle = 0;
  int      snk_idle = 0;
  bit      hold_req = 0;
  int      quiet_cycles = 0;
  bit      in_hs, out_hs;

  int sin_tbl [NPTS];
  int cos_tbl [NPTS];
  int smp_re [NPTS];
  int smp_im [NPTS];
  int bin_re [NPTS];
  int bin_im [NPTS];

  fft_radix4_dif_fixed dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  // ---------------- twiddle table ----------------
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic int sine_mag(input int m);
    logic [63:0] q, r, x, x2, term, sum, v;
    q = PI2_Q60 / NPTS;
    r = PI2_Q60 % NPTS;
    x = 64'd4 * (q * 64'(m) + (r * 64'(m)) / NPTS);
    x2 = q62_mul(x, x);
    term = x;
    sum = x;
    for (int k = 1; k < 24 && term != 64'd0; k++) begin
      term = q62_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    v = sum >> 47;
    return (v > 64'd32768) ? 32768 : int'(v);
  endfunction

  function automatic int sine_q15(input int i, ref int mag [QTR+1]);
    int m;
    bit neg;
    i = i % NPTS;
    neg = 0;
    if (i <= QTR) m = mag[i];
    else if (i <= 2 * QTR) m = mag[2 * QTR - i];
    else if (i <= 3 * QTR) begin m = mag[i - 2 * QTR]; neg = 1; end
    else begin m = mag[4 * QTR - i]; neg = 1; end
    if (neg) return -m;
    return (m > 32767) ? 32767 : m;
  endfunction

  task automatic build_twiddles();
    int mag [QTR+1];
    for (int m = 0; m <= QTR; m++) mag[m] = sine_mag(m);
    for (int i = 0; i < NPTS; i++) begin
      sin_tbl[i] = sine_q15(i, mag);
      cos_tbl[i] = sine_q15(i + QTR, mag);
    end
  endtask

  // ---------------- transform predictor ----------------
  function automatic int wrap16(input longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  task automatic radix4_bfly(ref int re [4], ref int im [4], input int w1, input int w2,
                             input int w3);
    longint r0, r1, r2, r3, i0, i1, i2, i3, a, b, c, d, e, f;
    r0 = re[0]; r1 = re[1]; r2 = re[2]; r3 = re[3];
    i0 = im[0]; i1 = im[1]; i2 = im[2]; i3 = im[3];
    a = (r0 + i1 - r2 - i3) >>> 1;
    b = (r0 - r1 + r2 - r3) >>> 1;
    c = (r0 - i1 - r2 + i3) >>> 1;
    d = (i0 - r1 - i2 + r3) >>> 1;
    e = (i0 - i1 + i2 - i3) >>> 1;
    f = (i0 + r1 - i2 - r3) >>> 1;
    re[0] = wrap16((r0 + r1 + r2 + r3) >>> 2);
    im[0] = wrap16((i0 + i1 + i2 + i3) >>> 2);
    re[1] = wrap16((a * cos_tbl[w1] + d * sin_tbl[w1]) >>> 16);
    im[1] = wrap16((d * cos_tbl[w1] - a * sin_tbl[w1]) >>> 16);
    re[2] = wrap16((b * cos_tbl[w2] + e * sin_tbl[w2]) >>> 16);
    im[2] = wrap16((e * cos_tbl[w2] - b * sin_tbl[w2]) >>> 16);
    re[3] = wrap16((c * cos_tbl[w3] + f * sin_tbl[w3]) >>> 16);
    im[3] = wrap16((f * cos_tbl[w3] - c * sin_tbl[w3]) >>> 16);
  endtask

  function automatic int digit_rev(input int x);
    int rev;
    rev = 0;
    for (int s = 1; s < NPTS; s = s << 2) begin
      rev = (rev << 2) | (x & 3);
      x = x >> 2;
    end
    return rev;
  endfunction

  task automatic fft_predict();
    int re [4], im [4];
    int step, leg, w1;
    step = 1;
    for (int span = NPTS; span > 4; span = span >> 2) begin
      leg = span >> 2;
      for (int g = 0; g < leg; g++) begin
        w1 = (g * step) % NPTS;
        for (int lo = g; lo + 3 * leg < NPTS; lo += span) begin
          for (int k = 0; k < 4; k++) begin
            re[k] = smp_re[lo + k * leg]; im[k] = smp_im[lo + k * leg];
          end
          radix4_bfly(re, im, w1, (2 * w1) % NPTS, (3 * w1) % NPTS);
          for (int k = 0; k < 4; k++) begin
            smp_re[lo + k * leg] = re[k]; smp_im[lo + k * leg] = im[k];
          end
        end
      end
      step = step << 2;
    end
    // last stage: unit twiddle, digit-reversed bin order
    for (int lo = 0; lo < NPTS; lo += 4) begin
      for (int k = 0; k < 4; k++) begin
        re[k] = smp_re[lo + k]; im[k] = smp_im[lo + k];
      end
      radix4_bfly(re, im, 0, 0, 0);
      for (int k = 0; k < 4; k++) begin
        bin_re[digit_rev(lo + k)] = re[k];
        bin_im[digit_rev(lo + k)] = im[k];
      end
    end
  endtask

  task automatic predict_item(input func_e f, input int idx, input int re, input int im);
    result_t r;
    if (f == FUNC_NONE) return;
    r.idx = idx[9:0];
    r.re = '0;
    r.im = '0;
    case (f)
      FUNC_WRITE: begin
        r.kind = KIND_ACK;
        smp_re[idx] = re;
        smp_im[idx] = im;
      end
      FUNC_RUN: begin
        r.kind = KIND_DONE;
        fft_predict();
      end
      default: begin
        r.kind = KIND_DATA;
        r.re = bin_re[idx][15:0];
        r.im = bin_im[idx][15:0];
      end
    endcase
    result_q.push_back(r);
  endtask

  // ---------------- stimulus ----------------
  task automatic send_item(input func_e f, input int idx, input int re, input int im);
    bit acc;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= {6'd0, im[15:0], re[15:0], idx[9:0]};
    acc = 0;
    while (!acc) begin
      #4 acc = s_axis_tready;
      @(posedge clk_i);
      if (!acc) @(negedge clk_i);
    end
    predict_item(f, idx, re, im);
  endtask

  function automatic int rand_part();
    case ($urandom_range(7))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(255) - 128;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  task automatic load_samples(input bit random_data);
    for (int i = 0; i < NPTS; i++) begin
      if (random_data) send_item(FUNC_WRITE, i, rand_part(), rand_part());
      else send_item(FUNC_WRITE, i, (i % 2) ? 32767 : -32768, (i % 4 < 2) ? 32767 : -32768);
    end
  endtask

  task automatic test_directed();
    load_samples(0);
    send_item(FUNC_RUN, 0, 0, 0);
    send_item(FUNC_READ, 0, 0, 0);
    send_item(FUNC_READ, 1023, 0, 0);
    send_item(FUNC_READ, 512, 0, 0);
    send_item(FUNC_NONE, 5, 1, 1);
    send_item(FUNC_READ, 1, 0, 0);
    // second run transforms the leftover stage values
    send_item(FUNC_RUN, 1023, 0, 0);
    for (int i = 0; i < 4; i++) send_item(FUNC_READ, i, 0, 0);
    send_item(FUNC_WRITE, 1023, 32767, -32768);
    send_item(FUNC_WRITE, 0, -32768, 32767);
  endtask

  // every sample is written by now; random writes overwrite a few before the run
  task automatic test_random(input int sidle, input int ridle, input bit pressure);
    int n;
    src_idle = sidle;
    snk_idle = ridle;
    if (pressure) hold_req = 1;
    for (n = 0; n < 24; n++) begin
      case ($urandom_range(9))
        0, 1, 2: send_item(FUNC_WRITE, $urandom_range(1023), rand_part(), rand_part());
        3: send_item(FUNC_NONE, $urandom_range(1023), rand_part(), rand_part());
        default: send_item(FUNC_READ, $urandom_range(1023), 0, 0);
      endcase
    end
    send_item(FUNC_RUN, $urandom_range(1023), 0, 0);
    for (n = 0; n < 4; n++) send_item(FUNC_READ, $urandom_range(1023), 0, 0);
  endtask

  // ---------------- receiver, checker, watchdog ----------------
  always @(negedge clk_i) begin : sink_ctl
    int hold;
    if (hold_req) begin
      hold = 400;
      hold_req = 0;
    end
    if (hold > 0) begin
      hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(negedge clk_i) begin : result_check
    result_t exp_r;
    #4;
    in_hs = s_axis_tvalid && s_axis_tready;
    out_hs = m_axis_tvalid && m_axis_tready;
    if (out_hs) begin
      if (result_q.size() == 0) begin
        report_mismatch("unexpected item kind", m_axis_tuser, -1);
      end else begin
        exp_r = result_q.pop_front();
        if (m_axis_tuser != exp_r.kind) report_mismatch("kind", m_axis_tuser, exp_r.kind);
        if (m_axis_tdata[9:0] != exp_r.idx)
          report_mismatch("index", m_axis_tdata[9:0], exp_r.idx);
        if (m_axis_tdata[25:10] != exp_r.re)
          report_mismatch("real", $signed(m_axis_tdata[25:10]), $signed(exp_r.re));
        if (m_axis_tdata[41:26] != exp_r.im)
          report_mismatch("imag", $signed(m_axis_tdata[41:26]), $signed(exp_r.im));
      end
    end
    if (in_hs || out_hs) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WD_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    build_twiddles();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    src_idle = 0;
    snk_idle = 0;
    test_directed();
    test_random(6, 80, 0);
    test_random(80, 6, 0);
    test_random(0, 0, 1);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### fft_radix4_dif_fixed.f
sv/fftr4_pkg.sv
sv/fftr4_twiddle.sv
sv/fftr4_mac.sv
sv/fftr4_core.sv
sv/fft_radix4_dif_fixed.sv
sim/tb_fft_radix4_dif_fixed.sv
